[rtl/frame_table_fifo_victim_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the frame table
// Shared property shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FRAME_TABLE_FIFO_VICTIM_ASSERT_SVH
`define FRAME_TABLE_FIFO_VICTIM_ASSERT_SVH

// Same-cycle implication
`define FTFV_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FTFV_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ftfv_pkg.sv]
// ---------------------------------------------------------------------------
// ftfv_pkg
// Sizes, operation codes and shared structs of the frame table.
// ---------------------------------------------------------------------------
package ftfv_pkg;

  // Table geometry
  localparam int FRAMES     = 32;
  localparam int PAGE_BITS  = 10;
  localparam int OWNER_BITS = 8;
  localparam int STAMP_BITS = 32;

  localparam int FIDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int STORE_W = PAGE_BITS + OWNER_BITS;

  // Port field widths
  localparam int FUNC_W     = 2;
  localparam int FRAME_W    = 5;
  localparam int VPAGE_W    = 10;
  localparam int OWNER_W    = 8;
  localparam int COUNT_W    = 6;
  localparam int COUNT_MAX  = 63;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Operation codes; any other code acts as a query
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // One step of the scan unit
  typedef struct packed {
    logic                  start;
    logic                  step;
    logic                  used;
    logic [STAMP_BITS-1:0] stamp;
  } scan_step_t;

  // Running results of the scan unit
  typedef struct packed {
    logic              found;
    logic [FIDX_W-1:0] first;
    logic [CNT_W-1:0]  count;
    logic [FIDX_W-1:0] victim;
  } scan_res_t;

endpackage

[rtl/ftfv_ram.sv]
// ---------------------------------------------------------------------------
// ftfv_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ftfv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/ftfv_scan.sv]
// ---------------------------------------------------------------------------
// ftfv_scan
// Shared compare unit: one frame a step for first free, free count and
// oldest stamp (strict less, so the lowest index wins ties).
// ---------------------------------------------------------------------------
module ftfv_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  ftfv_pkg::scan_step_t step_i,
  output ftfv_pkg::scan_res_t  res_o
);

  logic [ftfv_pkg::FIDX_W-1:0]     idx_r;
  logic                            first_r;
  logic [ftfv_pkg::STAMP_BITS-1:0] oldest_r;
  ftfv_pkg::scan_res_t             res_r;
  logic                            older;

  // The single stamp comparator
  assign older = first_r || (step_i.stamp < oldest_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      first_r  <= 1'b1;
      oldest_r <= '0;
      res_r    <= '0;
    end else if (step_i.start) begin
      idx_r    <= '0;
      first_r  <= 1'b1;
      res_r    <= '0;
    end else if (step_i.step) begin
      idx_r   <= idx_r + ftfv_pkg::FIDX_W'(1);
      first_r <= 1'b0;
      if (!step_i.used) begin
        res_r.count <= res_r.count + ftfv_pkg::CNT_W'(1);
        if (!res_r.found) begin
          res_r.found <= 1'b1;
          res_r.first <= idx_r;
        end
      end
      if (older) begin
        oldest_r     <= step_i.stamp;
        res_r.victim <= idx_r;
      end
    end
  end

  assign res_o = res_r;

endmodule

[rtl/frame_table_fifo_victim.sv]
// ---------------------------------------------------------------------------
// frame_table_fifo_victim
// Physical frame table with mark, clear and query, reporting first free
// frame, free count and FIFO victim after each operation.
// ---------------------------------------------------------------------------
//
//  channel | ports                         | fields (low bit up)
//  --------+-------------------------------+---------------------------------
//  in      | in_tvalid in_tready in_tdata  | func, frame, virtual_page, owner_id
//  out     | out_tvalid out_tready out_tdata | frame_used, stored_page,
//          |                               | stored_owner, found_free,
//          |                               | first_free, free_count, victim_frame
//
//  Each beat runs through update, a scan of every frame through the stamp RAM's
//  registered read port and the shared compare unit, and finish; the sequencer
//  then returns to idle, the only state in which a new beat is taken.
//  Reset clears all in-use bits and sets the stamp counter to one; the RAMs
//  need no clearing since a free frame reads as stamp zero and empty contents.
//  A pending result stalls only the finish state; no new beat enters until idle.
//
module frame_table_fifo_victim (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // func[1:0], frame[6:2], virtual_page[16:7], owner_id[24:17], zero fill
  input  logic [ftfv_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // frame_used[0], stored_page[10:1], stored_owner[18:11], found_free[19],
  // first_free[24:20], free_count[30:25], victim_frame[35:31], zero fill
  output logic [ftfv_pkg::OUT_DATA_W-1:0]   out_tdata
);

  `include "frame_table_fifo_victim_assert.svh"

  typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_SCAN, S_FINISH} state_t;

  state_t                            state_r;
  logic [ftfv_pkg::FUNC_W-1:0]       func_r;
  logic [ftfv_pkg::FIDX_W-1:0]       addr_r;
  logic                              fr_ok_r;
  logic [ftfv_pkg::PAGE_BITS-1:0]    page_r;
  logic [ftfv_pkg::OWNER_BITS-1:0]   owner_r;
  logic [ftfv_pkg::FRAMES-1:0]       in_use_r;
  logic [ftfv_pkg::STAMP_BITS-1:0]   stamp_cnt_r;
  logic [ftfv_pkg::CNT_W-1:0]        scan_cnt_r;
  logic                              eval_vld_r;
  logic                              eval_used_r;
  logic                              out_tvalid_r;
  logic [ftfv_pkg::OUT_DATA_W-1:0]   out_tdata_r;

  logic                              in_acc;
  logic                              is_mark;
  logic                              is_clear;
  logic                              scan_issue;
  logic                              load_out;
  logic [ftfv_pkg::FIDX_W-1:0]       scan_addr;
  logic [ftfv_pkg::STAMP_BITS-1:0]   stamp_rd;
  logic [ftfv_pkg::STORE_W-1:0]      store_rd;
  logic                              used_now;
  logic [ftfv_pkg::COUNT_W-1:0]      count_sat;
  logic [ftfv_pkg::OUT_DATA_W-1:0]   result;
  ftfv_pkg::scan_step_t              step;
  ftfv_pkg::scan_res_t               res;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Operation decode; unknown codes fall through to query
  always_comb begin
    is_mark  = 1'b0;
    is_clear = 1'b0;
    case (func_r)
      ftfv_pkg::FUNC_MARK:  is_mark  = fr_ok_r;
      ftfv_pkg::FUNC_CLEAR: is_clear = fr_ok_r;
      ftfv_pkg::FUNC_QUERY: ;
      default:              ;
    endcase
  end

  // Scan read issue
  assign scan_addr  = scan_cnt_r[ftfv_pkg::FIDX_W-1:0];
  assign scan_issue = (state_r == S_SCAN) &&
                      (32'(scan_cnt_r) < 32'(ftfv_pkg::FRAMES));

  // Stamp RAM: written on mark, read by the scan
  ftfv_ram #(
    .WIDTH (ftfv_pkg::STAMP_BITS),
    .DEPTH (ftfv_pkg::FRAMES)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   ((state_r == S_UPDATE) && is_mark),
    .wr_addr (addr_r),
    .wr_data (stamp_cnt_r),
    .rd_addr (scan_addr),
    .rd_data (stamp_rd)
  );

  // Page and owner RAM: read address stays on the addressed frame
  ftfv_ram #(
    .WIDTH (ftfv_pkg::STORE_W),
    .DEPTH (ftfv_pkg::FRAMES)
  ) u_store_ram (
    .clk     (clk),
    .wr_en   ((state_r == S_UPDATE) && is_mark),
    .wr_addr (addr_r),
    .wr_data ({owner_r, page_r}),
    .rd_addr (addr_r),
    .rd_data (store_rd)
  );

  // Scan unit feed; a free frame counts as stamp zero
  always_comb begin
    step.start = (state_r == S_UPDATE);
    step.step  = eval_vld_r;
    step.used  = eval_used_r;
    step.stamp = eval_used_r ? stamp_rd : '0;
  end

  ftfv_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .res_o  (res)
  );

  // Result assembly
  assign used_now  = fr_ok_r && in_use_r[addr_r];
  assign count_sat = (32'(res.count) > 32'(ftfv_pkg::COUNT_MAX)) ?
                     ftfv_pkg::COUNT_W'(ftfv_pkg::COUNT_MAX) :
                     ftfv_pkg::COUNT_W'(res.count);
  always_comb begin
    result        = '0;
    result[0]     = used_now;
    result[10:1]  = used_now ?
                    ftfv_pkg::VPAGE_W'(store_rd[ftfv_pkg::PAGE_BITS-1:0]) : '0;
    result[18:11] = used_now ?
                    ftfv_pkg::OWNER_W'(store_rd[ftfv_pkg::STORE_W-1:ftfv_pkg::PAGE_BITS])
                    : '0;
    result[19]    = res.found;
    result[24:20] = ftfv_pkg::FRAME_W'(res.first);
    result[30:25] = count_sat;
    result[35:31] = ftfv_pkg::FRAME_W'(res.victim);
  end

  assign load_out = (state_r == S_FINISH) && (!out_tvalid_r || out_tready);

  // Sequencer, table state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_use_r     <= '0;
      stamp_cnt_r  <= ftfv_pkg::STAMP_BITS'(1);
      scan_cnt_r   <= '0;
      eval_vld_r   <= 1'b0;
      eval_used_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      eval_vld_r  <= scan_issue;
      eval_used_r <= in_use_r[scan_addr];
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (is_mark) begin
            in_use_r[addr_r] <= 1'b1;
            if (stamp_cnt_r != '1) begin
              stamp_cnt_r <= stamp_cnt_r + ftfv_pkg::STAMP_BITS'(1);
            end
          end else if (is_clear) begin
            in_use_r[addr_r] <= 1'b0;
          end
          scan_cnt_r <= '0;
          state_r    <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_issue) begin
            scan_cnt_r <= scan_cnt_r + ftfv_pkg::CNT_W'(1);
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Input beat capture and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_tdata[1:0];
      addr_r  <= ftfv_pkg::FIDX_W'(in_tdata[6:2]);
      fr_ok_r <= 32'(in_tdata[6:2]) < 32'(ftfv_pkg::FRAMES);
      page_r  <= ftfv_pkg::PAGE_BITS'(in_tdata[16:7]);
      owner_r <= ftfv_pkg::OWNER_BITS'(in_tdata[24:17]);
    end
    if (load_out) begin
      out_tdata_r <= result;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  `FTFV_CHECK_NEXT(a_busy_after_accept, in_acc, !in_tready, "ready after accept")
  `FTFV_CHECK(a_stamp_nonzero, 1'b1, stamp_cnt_r != '0, "stamp counter reached zero")
  `FTFV_CHECK(a_count_bound, load_out, 32'(res.count) <= 32'(ftfv_pkg::FRAMES),
              "free count above table size")
  `FTFV_CHECK(a_victim_free, load_out && res.found, !in_use_r[res.victim],
              "victim is used while a free frame exists")

endmodule

[verif/frame_table_fifo_victim_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_table_fifo_victim_checker
// Watches both streams of the frame table, keeps a shadow table updated from
// every accepted input beat and compares each result beat, field by field,
// against the oldest predicted report.
// ---------------------------------------------------------------------------
module frame_table_fifo_victim_checker
  import ftfv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    reports_pending,
  output int                    fail_count
);

  // Result layout, last member in the lowest bits to match out_tdata
  typedef struct packed {
    logic [FRAME_W-1:0] victim;
    logic [COUNT_W-1:0] count;
    logic [FRAME_W-1:0] first;
    logic               found;
    logic [OWNER_W-1:0] owner;
    logic [VPAGE_W-1:0] page;
    logic               used;
  } frame_report_t;

  // Shadow frame table
  logic                  busy_q  [FRAMES];
  logic [PAGE_BITS-1:0]  page_q  [FRAMES];
  logic [OWNER_BITS-1:0] owner_q [FRAMES];
  logic [STAMP_BITS-1:0] stamp_q [FRAMES];
  logic [STAMP_BITS-1:0] next_stamp;

  frame_report_t report_q[$];
  int            errs = 0;

  // Apply one operation to the shadow table and build its report
  function automatic frame_report_t apply_op(input logic [IN_DATA_W-1:0] beat);
    logic [FUNC_W-1:0]     func;
    logic [FRAME_W-1:0]    fr;
    logic [VPAGE_W-1:0]    vpage;
    logic [OWNER_W-1:0]    owner;
    logic [STAMP_BITS-1:0] oldest;
    int unsigned           nfree;
    frame_report_t         r;
    func  = beat[1:0];
    fr    = beat[6:2];
    vpage = beat[16:7];
    owner = beat[24:17];
    r     = '0;
    if (fr < FRAMES) begin
      if (func == FUNC_MARK) begin
        busy_q[fr]  = 1'b1;
        page_q[fr]  = vpage[PAGE_BITS-1:0];
        owner_q[fr] = owner[OWNER_BITS-1:0];
        stamp_q[fr] = next_stamp;
        // counter sticks at all ones
        if (next_stamp != '1)
          next_stamp = next_stamp + 1'b1;
      end else if (func == FUNC_CLEAR) begin
        busy_q[fr]  = 1'b0;
        stamp_q[fr] = '0;
      end
      // free frames report empty contents
      if (busy_q[fr]) begin
        r.used  = 1'b1;
        r.page  = VPAGE_W'(page_q[fr]);
        r.owner = OWNER_W'(owner_q[fr]);
      end
    end

    // Scan: first free, free count, oldest stamp (lowest index on ties)
    oldest = stamp_q[0];
    nfree  = 0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!busy_q[i]) begin
        if (!r.found) begin
          r.found = 1'b1;
          r.first = FRAME_W'(i);
        end
        nfree++;
      end
      if (stamp_q[i] < oldest) begin
        oldest   = stamp_q[i];
        r.victim = FRAME_W'(i);
      end
    end
    r.count = (nfree > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(nfree);
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  // Monitor both channels; results are popped before the new beat is pushed
  always @(posedge clk) begin : monitor
    frame_report_t want;
    frame_report_t got;
    if (!rst_n) begin
      for (int i = 0; i < FRAMES; i++) begin
        busy_q[i]  = 1'b0;
        page_q[i]  = '0;
        owner_q[i] = '0;
        stamp_q[i] = '0;
      end
      next_stamp = 1;
      report_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(frame_report_t)-1:0];
        if (report_q.size() == 0) begin
          $error("result beat with no report pending");
          errs++;
        end else begin
          want = report_q.pop_front();
          compare_field("frame_used",   want.used,   got.used);
          compare_field("stored_page",  want.page,   got.page);
          compare_field("stored_owner", want.owner,  got.owner);
          compare_field("found_free",   want.found,  got.found);
          compare_field("first_free",   want.first,  got.first);
          compare_field("free_count",   want.count,  got.count);
          compare_field("victim_frame", want.victim, got.victim);
        end
      end
      if (in_tvalid && in_tready)
        report_q.push_back(apply_op(in_tdata));
    end
    reports_pending <= report_q.size();
    fail_count      <= errs;
  end

endmodule

[verif/frame_table_fifo_victim_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_table_fifo_victim_tb
// Drives mark, clear and query beats into the frame table with random gaps
// and output stalls: a directed opening, then random fill, drain and mixed
// phases that repeatedly fill the table and empty it again. The checker
// predicts and compares every result.
// ---------------------------------------------------------------------------
module frame_table_fifo_victim_tb;
  import ftfv_pkg::*;

  // Code three is not a named operation; the block treats it as a query
  localparam logic [FUNC_W-1:0] FUNC_ALT_QUERY = 2'd3;
  localparam int                RANDOM_BEATS   = 534;
  localparam int                SETTLE_CYCLES  = 2 * (FRAMES + 4);

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int reports_pending;
  int fail_count;

  // Stimulus-side view of which frames are in use, to aim marks and clears
  bit busy_shadow [FRAMES];
  bit tx_quiet;
  int rx_hold;
  bit rx_quiet;
  int rx_draw;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  frame_table_fifo_victim uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  frame_table_fifo_victim_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .reports_pending (reports_pending),
    .fail_count      (fail_count)
  );

  // Result side: random stall after each beat, with quiet stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold    <= 0;
      rx_quiet   <= 1'b0;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      rx_draw = rx_quiet ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 31) == 0)
        rx_quiet <= ~rx_quiet;
      rx_hold    <= rx_draw;
      out_tready <= (rx_draw == 0);
    end else if (rx_hold != 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= (rx_hold == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // One input beat; valid stays high across back-to-back beats
  task automatic send_op(input logic [FUNC_W-1:0] func, input int frame,
                         input int vpage, input int owner);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({OWNER_W'(owner), VPAGE_W'(vpage), FRAME_W'(frame), func});
    if (func == FUNC_MARK)
      busy_shadow[frame] = 1'b1;
    else if (func == FUNC_CLEAR)
      busy_shadow[frame] = 1'b0;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold off input until every predicted report has been checked
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
  endtask

  // Random frame, preferring one whose use flag matches want_busy
  function automatic int pick_frame(input bit want_busy);
    int hits [$];
    for (int i = 0; i < FRAMES; i++)
      if (busy_shadow[i] == want_busy)
        hits.push_back(i);
    if (hits.size() == 0)
      return $urandom_range(0, FRAMES - 1);
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  // Stimulus
  initial begin
    phase_t phase;
    int     len;
    int     roll;
    int     mark_pct;
    int     clear_pct;
    int     sent;
    tx_quiet = 1'b0;
    sent     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening
    send_op(FUNC_QUERY,     0,     0,     0);   // empty table
    send_op(FUNC_ALT_QUERY, 31,    1023,  255); // code three, field maxima
    send_op(FUNC_MARK,      0,     0,     0);
    send_op(FUNC_MARK,      31,    1023,  255);
    send_op(FUNC_MARK,      5,     'h2AA, 'h55);
    send_op(FUNC_MARK,      6,     'h155, 'hAA);
    send_op(FUNC_QUERY,     5,     'h3FF, 'hFF);
    send_op(FUNC_ALT_QUERY, 31,    0,     0);
    send_op(FUNC_MARK,      0,     'h3FF, 'h01); // remark takes a fresh stamp
    send_op(FUNC_CLEAR,     31,    0,     0);
    send_op(FUNC_QUERY,     31,    0,     0);    // cleared frame shows no contents
    send_op(FUNC_CLEAR,     20,    'h3FF, 'hFF); // clear of a never-used frame
    send_op(FUNC_CLEAR,     0,     0,     0);
    send_op(FUNC_MARK,      1,     'h200, 'h80);
    send_op(FUNC_MARK,      2,     'h001, 'h7F);
    send_op(FUNC_QUERY,     0,     0,     0);
    wait_drained();

    // Random phases: fill the table, drain it, or mix
    while (sent < RANDOM_BEATS) begin
      phase    = phase_t'($urandom_range(0, 2));
      len      = $urandom_range(20, 60);
      tx_quiet = ($urandom_range(0, 3) == 0);
      case (phase)
        PH_FILL: begin
          mark_pct  = 80;
          clear_pct = 8;
        end
        PH_DRAIN: begin
          mark_pct  = 10;
          clear_pct = 75;
        end
        default: begin
          mark_pct  = 40;
          clear_pct = 30;
        end
      endcase
      for (int k = 0; k < len && sent < RANDOM_BEATS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < mark_pct)
          send_op(FUNC_MARK,
                  ($urandom_range(0, 3) != 0) ? pick_frame(1'b0)
                                              : $urandom_range(0, FRAMES - 1),
                  $urandom_range(0, 1023), $urandom_range(0, 255));
        else if (roll < mark_pct + clear_pct)
          send_op(FUNC_CLEAR,
                  ($urandom_range(0, 3) != 0) ? pick_frame(1'b1)
                                              : $urandom_range(0, FRAMES - 1),
                  $urandom_range(0, 1023), $urandom_range(0, 255));
        else
          send_op(($urandom_range(0, 3) == 0) ? FUNC_ALT_QUERY : FUNC_QUERY,
                  $urandom_range(0, FRAMES - 1),
                  $urandom_range(0, 1023), $urandom_range(0, 255));
        sent++;
      end
      if ($urandom_range(0, 3) == 0)
        wait_drained();
    end

    // Let the last results drain, then give the verdict
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
